// ===== design/frame_refcount_allocator_defines.svh =====
// Assertion macros used by the frame allocator top level.
`ifndef FRAME_REFCOUNT_ALLOCATOR_DEFINES_SVH
`define FRAME_REFCOUNT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, held off during reset
`define FRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame allocator check failed");

// Next-cycle implication, held off during reset
`define FRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame allocator check failed");

`endif

// ===== design/fra_pkg.sv =====
// Types and constants for the frame reference-count allocator.
package fra_pkg;

    localparam int FRAMES_DEF = 4096;   // default number of frames
    localparam int WORD_BITS  = 64;     // frames per free-bitmap word
    localparam int WORD_SHIFT = 6;      // log2 of WORD_BITS
    localparam int PAGE_SHIFT = 12;     // 4 KiB frames
    localparam int PAGE_W     = 20;     // frame number bits of a 32-bit address
    localparam int CNT_W      = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_ADDREF = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_FREE      = 3'd1,
        ST_ALREADY_FREE = 3'd2,
        ST_RANGE        = 3'd3,
        ST_SAT          = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] frame_address;
        logic [11:0] frame_index;
        logic [7:0]  ref_count;
    } t_resp;

    // Strobes from the sequencer to the count store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ===== design/fra_store.sv =====
// Count memory, free-frame bitmap memory, per-word summary and reset clearing sweep.
module fra_store #(
    parameter int FRAMES = fra_pkg::FRAMES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fra_pkg::t_mem_ctl                i_ctl,
    input  logic [$clog2(FRAMES)-1:0]        i_rd_idx,
    input  logic [((FRAMES + fra_pkg::WORD_BITS - 1) / fra_pkg::WORD_BITS > 1 ?
                   $clog2((FRAMES + fra_pkg::WORD_BITS - 1) / fra_pkg::WORD_BITS) : 1)-1:0]
                                             i_rd_word_addr,
    input  logic [$clog2(FRAMES)-1:0]        i_wr_idx,
    input  logic [fra_pkg::CNT_W-1:0]        i_wr_cnt,
    input  logic [((FRAMES + fra_pkg::WORD_BITS - 1) / fra_pkg::WORD_BITS > 1 ?
                   $clog2((FRAMES + fra_pkg::WORD_BITS - 1) / fra_pkg::WORD_BITS) : 1)-1:0]
                                             i_wr_word_addr,
    input  logic [fra_pkg::WORD_BITS-1:0]    i_wr_word,
    output logic [fra_pkg::CNT_W-1:0]        o_rd_cnt,
    output logic [fra_pkg::WORD_BITS-1:0]    o_rd_word,
    output logic [(FRAMES + fra_pkg::WORD_BITS - 1) / fra_pkg::WORD_BITS-1:0] o_summary,
    output logic                             o_busy
);

    localparam int IDX_W   = $clog2(FRAMES);
    localparam int N_WORDS = (FRAMES + fra_pkg::WORD_BITS - 1) / fra_pkg::WORD_BITS;
    localparam int WIDX_W  = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
    localparam int FULL_W  = WIDX_W + fra_pkg::WORD_SHIFT;

    logic [fra_pkg::CNT_W-1:0]     mem_cnt [FRAMES];
    logic [fra_pkg::WORD_BITS-1:0] mem_map [N_WORDS];

    logic [fra_pkg::CNT_W-1:0]     r_rd_cnt;
    logic [fra_pkg::WORD_BITS-1:0] r_rd_word;
    logic [N_WORDS-1:0]            r_summary;
    logic                          r_clr_busy;
    logic [IDX_W-1:0]              r_clr_idx;

    logic [FULL_W-1:0]             w_clr_full;
    logic [WIDX_W-1:0]             w_clr_word;
    logic                          w_clr_map;
    logic [fra_pkg::WORD_BITS-1:0] w_clr_mask;

    // Clearing sweep: one count entry per cycle, bitmap words while in range
    assign w_clr_full = FULL_W'(r_clr_idx);
    assign w_clr_word = w_clr_full[WIDX_W-1:0];
    assign w_clr_map  = ({1'b0, w_clr_full} < (FULL_W+1)'(N_WORDS));

    // Only bits of frames that exist start out free
    always_comb begin
        for (int j = 0; j < fra_pkg::WORD_BITS; j++) begin
            w_clr_mask[j] = ({1'b0, w_clr_word, fra_pkg::WORD_SHIFT'(j)} <
                             (FULL_W+1)'(FRAMES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(FRAMES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Count memory
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_cnt[r_clr_idx] <= '0;
        end else if (i_ctl.wr_en) begin
            mem_cnt[i_wr_idx] <= i_wr_cnt;
        end
        if (i_ctl.rd_en) begin
            r_rd_cnt <= mem_cnt[i_rd_idx];
        end
    end

    // Free bitmap memory, a set bit marks a frame with count zero
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (w_clr_map) begin
                mem_map[w_clr_word] <= w_clr_mask;
            end
        end else if (i_ctl.wr_en) begin
            mem_map[i_wr_word_addr] <= i_wr_word;
        end
        if (i_ctl.rd_en) begin
            r_rd_word <= mem_map[i_rd_word_addr];
        end
    end

    // Summary: one bit per bitmap word that still holds a free frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summary <= '1;
        end else if (i_ctl.wr_en) begin
            r_summary[i_wr_word_addr] <= |i_wr_word;
        end
    end

    assign o_rd_cnt  = r_rd_cnt;
    assign o_rd_word = r_rd_word;
    assign o_summary = r_summary;
    assign o_busy    = r_clr_busy;

endmodule

// ===== design/frame_refcount_allocator.sv =====
// Top level of the frame reference-count allocator: request sequencer and result register.
// Keeps an 8-bit reference count for each of FRAMES 4 KiB frames starting at the
// configured base address. Allocate returns the lowest free frame (count zero) and
// sets its count to one; free decrements, add-reference increments up to 255.
// An accepted request reads the count memory and the free-bitmap word; the execute
// state then does the read-modify-write and loads the result register. The lowest
// free frame is found from a per-word summary register and a 64-bit bitmap word. A
// request with op 3 is accepted without leaving the idle state and gives no result.
// After reset a clearing pass over all FRAMES entries zeroes the counts; requests are
// stalled during it, configuration writes are always taken. A result waiting on a
// stalled output does not block the next request from being accepted; that request
// then waits in the execute state until the result register frees.
`include "frame_refcount_allocator_defines.svh"

module frame_refcount_allocator #(
    parameter int FRAMES = fra_pkg::FRAMES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fra_pkg::t_req  i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fra_pkg::t_resp o_out_data,
    // base address write channel
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [31:0]    i_cfg_data
);

    localparam int IDX_W   = $clog2(FRAMES);
    localparam int N_WORDS = (FRAMES + fra_pkg::WORD_BITS - 1) / fra_pkg::WORD_BITS;
    localparam int WIDX_W  = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
    localparam int FULL_W  = WIDX_W + fra_pkg::WORD_SHIFT;
    localparam int PW      = fra_pkg::PAGE_W;

    fra_pkg::t_state r_state, n_state;
    fra_pkg::t_op    r_op;
    logic [PW-1:0]   r_base;
    logic [PW-1:0]   r_page;
    logic            r_range_ok;
    logic            r_have_free;
    logic [IDX_W-1:0]  r_idx;
    logic [WIDX_W-1:0] r_word;
    logic [fra_pkg::WORD_SHIFT-1:0] r_bit;
    logic            r_out_valid;
    fra_pkg::t_resp  r_out, n_resp;

    fra_pkg::t_mem_ctl w_ctl;
    logic [fra_pkg::CNT_W-1:0]     w_rd_cnt;
    logic [fra_pkg::WORD_BITS-1:0] w_rd_word;
    logic [N_WORDS-1:0]            w_summary;
    logic                          w_busy;

    logic            w_in_fire;
    logic            w_out_free;
    logic            w_done;
    logic [PW-1:0]   w_in_page;
    logic [PW-1:0]   w_off;
    logic            w_in_range;
    logic [IDX_W-1:0]  w_in_idx;
    logic [FULL_W-1:0] w_in_full;
    logic              w_sum_any;
    logic [WIDX_W-1:0] w_sum_word;
    logic [WIDX_W-1:0] w_rd_word_addr;

    logic [fra_pkg::WORD_SHIFT-1:0] w_low_bit;
    logic [FULL_W-1:0]             w_alloc_full;
    logic [IDX_W-1:0]              w_alloc_idx;
    logic [PW:0]                   w_alloc_sum;
    logic [IDX_W-1:0]              w_e_idx;
    logic [31:0]                   w_e_idx32;
    logic [fra_pkg::WORD_BITS-1:0] w_mask;
    logic                          w_write;
    logic [fra_pkg::CNT_W-1:0]     w_wr_cnt;
    logic [fra_pkg::WORD_BITS-1:0] w_wr_word;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != fra_pkg::S_IDLE) || w_busy;
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_done      = (r_state == fra_pkg::S_EXEC) && w_out_free;

    // Base address register, low 12 bits dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base <= i_cfg_data[31:fra_pkg::PAGE_SHIFT];
        end
    end

    // Address to frame index
    assign w_in_page  = i_in_data.addr[31:fra_pkg::PAGE_SHIFT];
    assign w_off      = w_in_page - r_base;
    assign w_in_range = (w_in_page >= r_base) && ({1'b0, w_off} < (PW+1)'(FRAMES));
    assign w_in_idx   = w_off[IDX_W-1:0];
    assign w_in_full  = FULL_W'(w_in_idx);

    // Lowest bitmap word that still holds a free frame
    always_comb begin
        w_sum_any  = 1'b0;
        w_sum_word = '0;
        for (int i = N_WORDS - 1; i >= 0; i--) begin
            if (w_summary[i]) begin
                w_sum_any  = 1'b1;
                w_sum_word = WIDX_W'(i);
            end
        end
    end

    assign w_rd_word_addr = (i_in_data.op == fra_pkg::OP_ALLOC) ? w_sum_word
                                                                : w_in_full[FULL_W-1:fra_pkg::WORD_SHIFT];

    // Request latch at accept
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op        <= i_in_data.op;
            r_page      <= w_in_page;
            r_range_ok  <= w_in_range;
            r_have_free <= w_sum_any;
            r_idx       <= w_in_idx;
            r_word      <= w_rd_word_addr;
            r_bit       <= w_in_full[fra_pkg::WORD_SHIFT-1:0];
        end
    end

    // Lowest free frame within the fetched bitmap word
    always_comb begin
        w_low_bit = '0;
        for (int i = fra_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (w_rd_word[i]) begin
                w_low_bit = fra_pkg::WORD_SHIFT'(i);
            end
        end
    end

    assign w_alloc_full = {r_word, w_low_bit};
    assign w_alloc_idx  = w_alloc_full[IDX_W-1:0];
    assign w_alloc_sum  = {1'b0, r_base} + (PW+1)'(w_alloc_idx);
    assign w_e_idx      = (r_op == fra_pkg::OP_ALLOC) ? w_alloc_idx : r_idx;
    assign w_e_idx32    = 32'(w_e_idx);
    assign w_mask       = fra_pkg::WORD_BITS'(1) <<
                          ((r_op == fra_pkg::OP_ALLOC) ? w_low_bit : r_bit);

    // Read-modify-write of the fetched count and bitmap word, result build
    always_comb begin
        w_write                = 1'b0;
        w_wr_cnt               = w_rd_cnt;
        w_wr_word              = w_rd_word;
        n_resp.status          = fra_pkg::ST_RANGE;
        n_resp.frame_address   = '0;
        n_resp.frame_index     = '0;
        n_resp.ref_count       = '0;
        case (r_op)
            fra_pkg::OP_ALLOC: begin
                if (!r_have_free || w_alloc_sum[PW]) begin
                    n_resp.status = fra_pkg::ST_NO_FREE;
                end else begin
                    w_write              = 1'b1;
                    w_wr_cnt             = fra_pkg::CNT_W'(1);
                    w_wr_word            = w_rd_word & ~w_mask;
                    n_resp.status        = fra_pkg::ST_OK;
                    n_resp.frame_address = {w_alloc_sum[PW-1:0], 12'h000};
                    n_resp.frame_index   = w_e_idx32[11:0];
                    n_resp.ref_count     = fra_pkg::CNT_W'(1);
                end
            end
            fra_pkg::OP_FREE: begin
                if (r_range_ok) begin
                    if (w_rd_cnt == '0) begin
                        n_resp.status      = fra_pkg::ST_ALREADY_FREE;
                        n_resp.frame_index = w_e_idx32[11:0];
                    end else begin
                        w_write  = 1'b1;
                        w_wr_cnt = w_rd_cnt - 1'b1;
                        // count drops to zero: frame is free again
                        if (w_rd_cnt == fra_pkg::CNT_W'(1)) begin
                            w_wr_word = w_rd_word | w_mask;
                        end
                        n_resp.status        = fra_pkg::ST_OK;
                        n_resp.frame_address = {r_page, 12'h000};
                        n_resp.frame_index   = w_e_idx32[11:0];
                        n_resp.ref_count     = w_rd_cnt - 1'b1;
                    end
                end
            end
            fra_pkg::OP_ADDREF: begin
                if (r_range_ok) begin
                    if (w_rd_cnt == fra_pkg::CNT_MAX) begin
                        n_resp.status      = fra_pkg::ST_SAT;
                        n_resp.frame_index = w_e_idx32[11:0];
                        n_resp.ref_count   = fra_pkg::CNT_MAX;
                    end else begin
                        w_write  = 1'b1;
                        w_wr_cnt = w_rd_cnt + 1'b1;
                        // a free frame becomes taken
                        if (w_rd_cnt == '0) begin
                            w_wr_word = w_rd_word & ~w_mask;
                        end
                        n_resp.status        = fra_pkg::ST_OK;
                        n_resp.frame_address = {r_page, 12'h000};
                        n_resp.frame_index   = w_e_idx32[11:0];
                        n_resp.ref_count     = w_rd_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_resp.status = fra_pkg::ST_RANGE;
            end
        endcase
    end

    // Memory strobes
    always_comb begin
        w_ctl.rd_en = w_in_fire && (i_in_data.op != fra_pkg::OP_NONE);
        w_ctl.wr_en = w_done && w_write;
    end

    fra_store #(
        .FRAMES(FRAMES)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_rd_idx       (w_in_idx),
        .i_rd_word_addr (w_rd_word_addr),
        .i_wr_idx       (w_e_idx),
        .i_wr_cnt       (w_wr_cnt),
        .i_wr_word_addr (r_word),
        .i_wr_word      (w_wr_word),
        .o_rd_cnt       (w_rd_cnt),
        .o_rd_word      (w_rd_word),
        .o_summary      (w_summary),
        .o_busy         (w_busy)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fra_pkg::S_IDLE: begin
                if (w_in_fire && (i_in_data.op != fra_pkg::OP_NONE)) begin
                    n_state = fra_pkg::S_EXEC;
                end
            end
            fra_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_state = fra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fra_pkg::S_IDLE;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= n_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `FRA_ASSERT_IMP(a_stall_while_clearing, i_clk, i_rst_n, w_busy, o_in_stall)
    `FRA_ASSERT_NXT(a_done_gives_beat, i_clk, i_rst_n, w_done, o_out_valid && (r_state == fra_pkg::S_IDLE))
    `FRA_ASSERT_IMP(a_fail_fields_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status == fra_pkg::ST_NO_FREE || o_out_data.status == fra_pkg::ST_RANGE), (o_out_data.frame_address == '0) && (o_out_data.frame_index == '0) && (o_out_data.ref_count == '0))
    `FRA_ASSERT_IMP(a_sat_count, i_clk, i_rst_n, o_out_valid && (o_out_data.status == fra_pkg::ST_SAT), o_out_data.ref_count == fra_pkg::CNT_MAX)

endmodule

// ===== sim/fra_checker.sv =====
// Scoreboard for the frame allocator: tracks counts and base address, predicts and compares results.
`timescale 1ns / 1ps

module fra_checker #(
    parameter int FRAMES = fra_pkg::FRAMES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  fra_pkg::t_req  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  fra_pkg::t_resp i_out_data,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [31:0]    i_cfg_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_checked,
    output logic [4:0]     o_status_seen
);
    import fra_pkg::*;

    logic [7:0]  frame_refs [FRAMES];
    logic [31:0] base_addr;
    t_resp       result_q [$];
    int          err_count;
    int          checked;
    logic [4:0]  seen;

    // Applies one request to the shadow counts; returns 1 when a result is due
    function automatic bit predict_frame_op(input t_req req, output t_resp res);
        logic [32:0] fa;
        logic [31:0] aligned;
        int unsigned idx;
        res = '{status: ST_OK, frame_address: '0, frame_index: '0, ref_count: '0};
        if (req.op == OP_NONE)
            return 1'b0;
        if (req.op == OP_ALLOC) begin
            res.status = ST_NO_FREE;
            for (int i = 0; i < FRAMES; i++) begin
                fa = {1'b0, base_addr} + (33'(i) << PAGE_SHIFT);
                // frames past the top of the 32-bit space do not exist
                if (fa > 33'h0_FFFF_F000)
                    break;
                if (frame_refs[i] == 8'd0) begin
                    frame_refs[i]     = 8'd1;
                    res.status        = ST_OK;
                    res.frame_address = fa[31:0];
                    res.frame_index   = 12'(i);
                    res.ref_count     = 8'd1;
                    break;
                end
            end
            return 1'b1;
        end
        // free and add-reference need an address inside the frame window
        aligned = req.addr & 32'hFFFF_F000;
        if (aligned < base_addr) begin
            res.status = ST_RANGE;
            return 1'b1;
        end
        idx = (aligned - base_addr) >> PAGE_SHIFT;
        if (idx >= FRAMES) begin
            res.status = ST_RANGE;
            return 1'b1;
        end
        res.frame_index = 12'(idx);
        if (req.op == OP_FREE) begin
            if (frame_refs[idx] == 8'd0) begin
                res.status = ST_ALREADY_FREE;
                return 1'b1;
            end
            frame_refs[idx] = frame_refs[idx] - 8'd1;
        end else begin
            if (frame_refs[idx] == CNT_MAX) begin
                res.status    = ST_SAT;
                res.ref_count = CNT_MAX;
                return 1'b1;
            end
            frame_refs[idx] = frame_refs[idx] + 8'd1;
        end
        res.frame_address = base_addr + (32'(idx) << PAGE_SHIFT);
        res.ref_count     = frame_refs[idx];
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // Results are handled before requests: a beat accepted now cannot answer this edge
    always @(posedge i_clk) begin : watch
        t_resp want;
        t_resp pred;
        if (!i_rst_n) begin
            foreach (frame_refs[i])
                frame_refs[i] = '0;
            base_addr = '0;
            result_q.delete();
            err_count = 0;
            checked   = 0;
            seen      = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    err_count++;
                    $display("%0t: stray result, expected none, actual %p", $time, i_out_data);
                end else begin
                    want = result_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_data.status));
                    check_field("frame_address", want.frame_address, i_out_data.frame_address);
                    check_field("frame_index", 32'(want.frame_index),
                                32'(i_out_data.frame_index));
                    check_field("ref_count", 32'(want.ref_count), 32'(i_out_data.ref_count));
                    seen[want.status] = 1'b1;
                    checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                base_addr = i_cfg_data & 32'hFFFF_F000;
            if (i_in_valid && !i_in_stall && predict_frame_op(i_in_data, pred))
                result_q.push_back(pred);
        end
        o_errors      <= err_count;
        o_pending     <= result_q.size();
        o_checked     <= checked;
        o_status_seen <= seen;
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the frame allocator: clock, reset, request and base address stimulus.
`timescale 1ns / 1ps

module tb;
    import fra_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_req        in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_resp       out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int          errors;
    int          pending;
    int          checked;
    logic [4:0]  status_seen;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          items_sent  = 0;
    int          base_writes = 0;
    int          cycles      = 0;
    logic [31:0] base_now    = '0;

    frame_refcount_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    fra_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    // Frames whose address still fits in 32 bits under the current base
    function automatic int reach_frames();
        logic [31:0] span;
        span = (32'hFFFF_F000 - base_now) >> PAGE_SHIFT;
        return (span >= 32'd4095) ? FRAMES_DEF : int'(span) + 1;
    endfunction

    function automatic logic [31:0] addr_of(input int k);
        return base_now + (32'(k) << PAGE_SHIFT) + 32'($urandom_range(4095));
    endfunction

    // Below the base, past the last frame, or anywhere
    function automatic logic [31:0] stray_addr();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0 && base_now != 0)
            return $urandom_range(base_now - 1, 0);
        if (pick == 1 && base_now <= 32'hFEFF_F000)
            return base_now + 32'h0100_0000
                 + $urandom_range(32'hFFFF_FFFF - base_now - 32'h0100_0000, 0);
        return $urandom;
    endfunction

    // One request beat; valid is left high so back-to-back beats need no second assignment
    task automatic send_req(input t_op op, input logic [31:0] addr);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: op, addr: addr};
        do @(posedge clk); while (in_stall);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // Hold off until every predicted result is back, plus slack for an op 3 in flight
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_now = value & 32'hFFFF_F000;
        base_writes++;
    endtask

    task automatic run_phase(input int tx, input int rx, input logic [31:0] base,
                             input int budget, input bit pump);
        int  first;
        int  win;
        int  kind;
        int  n;
        bit  paused;
        bit  pumped;
        write_base(base);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        first  = items_sent;
        paused = 1'b0;
        pumped = 1'b0;
        win    = (reach_frames() < 40) ? reach_frames() : 40;
        while (items_sent - first < budget) begin
            kind = $urandom_range(99);
            n    = $urandom_range(5, 1);
            // mostly traffic on the low frames that allocation hands out
            if (kind < 30)
                repeat (n) send_req(OP_ALLOC, $urandom);
            else if (kind < 55)
                repeat (n) send_req(OP_ADDREF, addr_of($urandom_range(win - 1)));
            else if (kind < 78)
                repeat (n) send_req(OP_FREE, addr_of($urandom_range(win - 1)));
            else if (kind < 88)
                repeat (n) send_req(t_op'($urandom_range(2)), addr_of($urandom_range(win - 1)));
            else if (kind < 97)
                send_req(t_op'($urandom_range(2, 1)), stray_addr());
            else
                send_req(OP_NONE, $urandom);
            if ((!paused && items_sent - first >= budget / 2) || $urandom_range(49) == 0) begin
                drain();
                paused = 1'b1;
            end
            // walk one frame's count up into saturation
            if (pump && !pumped && items_sent - first >= 40) begin
                n = $urandom_range(win - 1);
                repeat (257) send_req(OP_ADDREF, addr_of(n));
                pumped = 1'b1;
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: base zero after reset
        tx_idle_pct = 10;
        rx_idle_pct = 74;
        send_req(OP_ALLOC, 32'h0000_0000);
        send_req(OP_ALLOC, 32'hFFFF_FFFF);
        send_req(OP_ADDREF, 32'h0000_0FFF);
        send_req(OP_FREE, 32'h0000_1000);
        send_req(OP_FREE, 32'h0000_1ABC);     // frame already free
        send_req(OP_ALLOC, 32'h0000_0000);
        send_req(OP_ADDREF, 32'h00FF_F000);   // last frame
        send_req(OP_FREE, 32'h00FF_FFFF);
        send_req(OP_ADDREF, 32'h0100_0000);   // one past the last frame
        send_req(OP_FREE, 32'hFFFF_FFFF);
        send_req(OP_NONE, 32'hFFFF_FFFF);
        send_req(OP_ALLOC, 32'h5555_5555);

        // Directed: top base, only one frame below 4 GiB
        write_base(32'hFFFF_FFFF);
        send_req(OP_ALLOC, 32'h0000_0000);
        send_req(OP_ADDREF, 32'hFFFF_F123);
        send_req(OP_FREE, 32'h0000_0000);     // below base
        send_req(OP_FREE, 32'hFFFF_FFFF);
        send_req(OP_ALLOC, 32'hAAAA_AAAA);

        // Directed: mid base with junk in the low bits
        write_base(32'h0010_0FFF);
        send_req(OP_ALLOC, 32'h0000_0000);
        send_req(OP_FREE, 32'h000F_F000);     // just below base
        send_req(OP_ADDREF, 32'h0110_0000);   // just past the window
        send_req(OP_ADDREF, 32'h010F_FFFF);   // last frame of the window
        send_req(OP_NONE, 32'h0000_0000);

        run_phase(10, 74, 32'h0000_0FFF, 100, 1'b0);
        run_phase(74, 10, $urandom_range(32'h7FFF_FFFF), 100, 1'b0);
        run_phase(0, 0, 32'hFFFF_0000 | $urandom_range(4095), 170, 1'b1);

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests over %0d base address settings, %0d results compared.",
                 items_sent, base_writes + 1, checked);
        $display("Status codes returned (one bit per code, ok at bit 0): %b", status_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/fra_pkg.sv
design/fra_store.sv
design/frame_refcount_allocator.sv
sim/fra_checker.sv
sim/tb.sv
